@@ rtl/npss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npss_pkg: shared constants and types of the nine-point stencil sweep
// register indexes, mode codes, configuration and job words, saturation
// ----------------------------------------------------------------------------
package npss_pkg;

    localparam int MAX_ROW_LENGTH = 1024;
    localparam int VALUE_BITS     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int TAPS           = 9;
    localparam int CENTRE_TAP     = 4;
    localparam int ROW_COUNT_MAX  = 4096;
    localparam int JOB_QUEUE_DEPTH = 2;

    localparam int ROW_W      = 12;
    localparam int COL_W      = 10;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 13;
    localparam int MODE_W     = 2;
    localparam int OMEGA_W    = 18;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // accumulator holds nine products plus the right-hand side
    localparam int ACC_W = 2 * VALUE_BITS - FRAC_BITS + 4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OMEGA      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG_TOL   = 3'd4;

    localparam logic [MODE_W-1:0] MODE_AX     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESID  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_JACOBI = 2'd2;

    localparam logic [MODE_W-1:0]  RST_MODE       = MODE_RESID;
    localparam logic [LEN_W-1:0]   RST_ROW_LENGTH = 11'd1024;
    localparam logic [CNT_W-1:0]   RST_ROW_COUNT  = 13'd1024;
    localparam logic [OMEGA_W-1:0] RST_OMEGA      = 18'd65536;
    localparam logic [TOL_W-1:0]   RST_DIAG_TOL   = 16'd1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEN_W-1:0]   row_length;
        logic [CNT_W-1:0]   row_count;
        logic [OMEGA_W-1:0] omega;
        logic [TOL_W-1:0]   diag_tol;
    } cfg_t;

    typedef struct packed {
        logic [TAPS-1:0][VALUE_BITS-1:0] win;
        logic [TAPS-1:0][VALUE_BITS-1:0] coef;
        logic [VALUE_BITS-1:0]           rhs;
        logic [ROW_W-1:0]                row;
        logic [COL_W-1:0]                col;
        logic                            last;
    } job_t;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

    function automatic logic [VALUE_BITS-1:0] sat_val(input logic signed [ACC_W-1:0] v);
        logic [VALUE_BITS-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[VALUE_BITS-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[VALUE_BITS-1:0];
        else
            r = v[VALUE_BITS-1:0];
        return r;
    endfunction

endpackage

@@ rtl/npss_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npss_front: grid walker and window builder
// keeps two rows of x and the delayed coefficients, emits interior jobs
// ----------------------------------------------------------------------------
module npss_front #(
    parameter int MAX_ROW_LENGTH = npss_pkg::MAX_ROW_LENGTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  npss_pkg::cfg_t                      cfg,
    input  logic                                push,
    output logic                                full,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] x_value,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] rhs_value,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_up_left,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_up,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_up_right,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_left,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_centre,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_right,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_down_left,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_down,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_down_right,
    input  logic                                q_full,
    output logic                                q_push,
    output npss_pkg::job_t                      q_job
);

    localparam int VB   = npss_pkg::VALUE_BITS;
    localparam int TAPS = npss_pkg::TAPS;
    localparam int CW   = $clog2(MAX_ROW_LENGTH);
    localparam int LW   = (npss_pkg::LEN_W > CW + 1) ? npss_pkg::LEN_W : CW + 1;
    localparam int RW   = npss_pkg::ROW_W;
    localparam int NW   = npss_pkg::CNT_W;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_PROC = 2'b10
    } fstate_t;

    typedef logic [TAPS:0][VB-1:0] centre_t;

    fstate_t state_reg, state_next;

    logic [VB-1:0] line_mem [2][MAX_ROW_LENGTH];
    centre_t       delay_mem [MAX_ROW_LENGTH];

    logic [VB-1:0]          x_item_reg;
    centre_t                centre_item_reg;
    logic [VB-1:0]          lrd_up_reg;
    logic [VB-1:0]          lrd_mid_reg;
    centre_t                crd_reg;
    centre_t                hold_reg;
    logic [2:0][2:0][VB-1:0] win_reg, win_next;
    logic [RW-1:0]          row_reg, row_next;
    logic [CW-1:0]          col_reg, col_next;

    logic          accept, commit, interior, last;
    logic [LW-1:0] len_c, c_inc;
    logic [NW-1:0] cnt_c, r_inc;

    assign accept = (state_reg == F_IDLE) && push;
    assign full   = (state_reg != F_IDLE);
    assign commit = (state_reg == F_PROC) && (!interior || !q_full);
    assign q_push = (state_reg == F_PROC) && interior && !q_full;

    always_comb
    begin
        len_c = LW'(cfg.row_length);
        if (len_c < LW'(3))
            len_c = LW'(3);
        else if (len_c > LW'(MAX_ROW_LENGTH))
            len_c = LW'(MAX_ROW_LENGTH);
        cnt_c = cfg.row_count;
        if (cnt_c < NW'(3))
            cnt_c = NW'(3);
        else if (cnt_c > NW'(npss_pkg::ROW_COUNT_MAX))
            cnt_c = NW'(npss_pkg::ROW_COUNT_MAX);
    end

    assign interior = (row_reg >= RW'(2)) && (NW'(row_reg) <= cnt_c - NW'(1))
                   && (col_reg >= CW'(2)) && (LW'(col_reg) <= len_c - LW'(1));
    assign last = (NW'(row_reg) == cnt_c - NW'(1)) && (LW'(col_reg) == len_c - LW'(1));

    always_comb
    begin
        c_inc = LW'(col_reg) + LW'(1);
        r_inc = NW'(row_reg);
        col_next = CW'(c_inc);
        if (c_inc >= len_c)
        begin
            col_next = '0;
            r_inc = NW'(row_reg) + NW'(1);
        end
        row_next = RW'(r_inc);
        if (r_inc >= cnt_c)
            row_next = '0;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = lrd_up_reg;
        win_next[1][2] = lrd_mid_reg;
        win_next[2][2] = x_item_reg;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                q_job.win[i*3+j] = win_next[i][j];
        for (int k = 0; k < TAPS; k++)
            q_job.coef[k] = hold_reg[k+1];
        q_job.rhs  = hold_reg[0];
        q_job.row  = row_reg - RW'(1);
        q_job.col  = npss_pkg::COL_W'(col_reg - CW'(1));
        q_job.last = last;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (push) state_next = F_PROC;
            F_PROC: if (commit) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // line and delay stores
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lrd_up_reg  <= line_mem[row_reg[0]][col_reg];
            lrd_mid_reg <= line_mem[~row_reg[0]][col_reg];
            crd_reg     <= delay_mem[col_reg];
        end
        if (commit)
        begin
            line_mem[row_reg[0]][col_reg] <= x_item_reg;
            delay_mem[col_reg]            <= centre_item_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_item_reg         <= x_value;
            centre_item_reg[0] <= rhs_value;
            centre_item_reg[1] <= coef_up_left;
            centre_item_reg[2] <= coef_up;
            centre_item_reg[3] <= coef_up_right;
            centre_item_reg[4] <= coef_left;
            centre_item_reg[5] <= coef_centre;
            centre_item_reg[6] <= coef_right;
            centre_item_reg[7] <= coef_down_left;
            centre_item_reg[8] <= coef_down;
            centre_item_reg[9] <= coef_down_right;
        end
        if (commit)
            hold_reg <= crd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            win_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                win_reg <= win_next;
            end
        end
    end

endmodule

@@ rtl/npss_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npss_queue: short job queue between front and back
// two entries, first in first out
// ----------------------------------------------------------------------------
module npss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  npss_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output npss_pkg::job_t pop_job
);

    localparam int DEPTH = npss_pkg::JOB_QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    npss_pkg::job_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CNTW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNTW'(1);
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("job pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from an empty queue");

endmodule

@@ rtl/npss_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npss_back: stencil arithmetic engine
// shared multiplier for the nine taps, radix-4 divider, output register
// ----------------------------------------------------------------------------
module npss_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  npss_pkg::cfg_t                         cfg,
    input  logic                                   job_valid,
    input  npss_pkg::job_t                         job,
    output logic                                   job_pop,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [npss_pkg::VALUE_BITS-1:0] result_value,
    output logic [npss_pkg::ROW_W-1:0]             point_row,
    output logic [npss_pkg::COL_W-1:0]             point_col,
    output logic                                   diag_fault,
    output logic                                   last_point
);

    localparam int VB      = npss_pkg::VALUE_BITS;
    localparam int FB      = npss_pkg::FRAC_BITS;
    localparam int AW      = npss_pkg::ACC_W;
    localparam int TAPS    = npss_pkg::TAPS;
    localparam int NUM_W   = VB + FB;
    localparam int DIV_CYCLES = NUM_W / 2;
    localparam int KW      = 5;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_MAC  = 6'b000010,
        B_PREP = 6'b000100,
        B_DIV  = 6'b001000,
        B_JAC  = 6'b010000,
        B_OUT  = 6'b100000
    } bstate_t;

    bstate_t state_reg;

    npss_pkg::job_t          job_reg;
    logic [KW-1:0]           k_reg;
    logic signed [2*VB-1:0]  prod_reg;
    logic signed [AW-1:0]    offsum_reg, dprod_reg, p1_reg;
    logic [VB-1:0]           rem_reg, divisor_reg;
    logic [NUM_W-1:0]        num_reg;
    logic                    neg_reg;
    logic signed [VB-1:0]    quot_reg;
    logic [VB-1:0]           res_reg;
    logic                    fault_reg;
    logic                    out_valid_reg;

    logic signed [VB-1:0]    mul_a, mul_b, one_minus_w, xc, diag, v_sat;
    logic [3:0]              tap_idx, prev_idx;
    logic signed [AW-1:0]    term, rhs_ext;
    logic [VB-1:0]           abs_d, abs_v;
    logic                    fault_now;
    logic [VB-1:0]           rem_step;
    logic [NUM_W-1:0]        num_step;
    logic [VB:0]             trial;
    logic signed [VB-1:0]    quot_sat;
    logic                    load_out;

    assign xc          = $signed(job_reg.win[npss_pkg::CENTRE_TAP]);
    assign diag        = $signed(job_reg.coef[npss_pkg::CENTRE_TAP]);
    assign one_minus_w = VB'(1 << FB) - VB'(cfg.omega);
    assign rhs_ext     = AW'($signed(job_reg.rhs));
    assign term        = AW'(prod_reg >>> FB);
    assign tap_idx     = (k_reg < KW'(TAPS)) ? k_reg[3:0] : 4'd0;
    assign prev_idx    = k_reg[3:0] - 4'd1;
    assign abs_d       = diag[VB-1] ? (~diag + VB'(1)) : diag;
    assign fault_now   = (diag == '0) || (abs_d < VB'(cfg.diag_tol));
    assign v_sat       = npss_pkg::sat_val(rhs_ext - offsum_reg);
    assign abs_v       = v_sat[VB-1] ? (~v_sat + VB'(1)) : v_sat;
    assign job_pop     = (state_reg == B_IDLE) && job_valid;
    assign load_out    = (state_reg == B_OUT) && (!out_valid_reg || pop);
    assign empty       = !out_valid_reg;

    always_comb
    begin
        mul_a = $signed(job_reg.coef[tap_idx]);
        mul_b = $signed(job_reg.win[tap_idx]);
        if (state_reg == B_JAC)
        begin
            if (k_reg == '0)
            begin
                mul_a = one_minus_w;
                mul_b = xc;
            end
            else
            begin
                mul_a = VB'(cfg.omega);
                mul_b = quot_reg;
            end
        end
    end

    // two restoring steps per cycle
    always_comb
    begin
        rem_step = rem_reg;
        num_step = num_reg;
        for (int s = 0; s < 2; s++)
        begin
            trial    = {rem_step, num_step[NUM_W-1]};
            num_step = {num_step[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial       = trial - {1'b0, divisor_reg};
                num_step[0] = 1'b1;
            end
            rem_step = trial[VB-1:0];
        end
    end

    always_comb
    begin
        if (num_reg[NUM_W-1:VB-1] != '0)
            quot_sat = neg_reg ? npss_pkg::SAT_LO[VB-1:0] : npss_pkg::SAT_HI[VB-1:0];
        else if (neg_reg)
            quot_sat = -$signed(num_reg[VB-1:0]);
        else
            quot_sat = $signed(num_reg[VB-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job;
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            B_IDLE:
            begin
                offsum_reg <= '0;
                dprod_reg  <= '0;
            end
            B_MAC:
            begin
                if (k_reg != '0)
                begin
                    if (prev_idx == 4'(npss_pkg::CENTRE_TAP))
                        dprod_reg <= term;
                    else
                        offsum_reg <= offsum_reg + term;
                end
            end
            B_PREP:
            begin
                fault_reg <= 1'b0;
                if (cfg.mode == npss_pkg::MODE_JACOBI)
                begin
                    if (fault_now)
                    begin
                        fault_reg <= 1'b1;
                        res_reg   <= xc;
                    end
                    rem_reg     <= '0;
                    num_reg     <= {abs_v, {FB{1'b0}}};
                    divisor_reg <= abs_d;
                    neg_reg     <= v_sat[VB-1] ^ diag[VB-1];
                end
                else if (cfg.mode == npss_pkg::MODE_RESID)
                    res_reg <= npss_pkg::sat_val(rhs_ext - offsum_reg - dprod_reg);
                else
                    res_reg <= npss_pkg::sat_val(offsum_reg + dprod_reg);
            end
            B_DIV:
            begin
                rem_reg <= rem_step;
                num_reg <= num_step;
            end
            B_JAC:
            begin
                if (k_reg == '0)
                    quot_reg <= quot_sat;
                else if (k_reg == KW'(1))
                    p1_reg <= term;
                else
                    res_reg <= npss_pkg::sat_val(p1_reg + term);
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            result_value <= res_reg;
            point_row    <= job_reg.row;
            point_col    <= job_reg.col;
            diag_fault   <= fault_reg;
            last_point   <= job_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    k_reg <= '0;
                    if (job_valid)
                        state_reg <= B_MAC;
                end
                B_MAC:
                begin
                    k_reg <= k_reg + KW'(1);
                    if (k_reg == KW'(TAPS))
                        state_reg <= B_PREP;
                end
                B_PREP:
                begin
                    k_reg <= '0;
                    if (cfg.mode == npss_pkg::MODE_JACOBI && !fault_now)
                        state_reg <= B_DIV;
                    else
                        state_reg <= B_OUT;
                end
                B_DIV:
                begin
                    k_reg <= k_reg + KW'(1);
                    if (k_reg == KW'(DIV_CYCLES - 1))
                    begin
                        k_reg     <= '0;
                        state_reg <= B_JAC;
                    end
                end
                B_JAC:
                begin
                    k_reg <= k_reg + KW'(1);
                    if (k_reg == KW'(2))
                        state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (load_out)
                        state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    a_fault_only_jacobi: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && diag_fault) |-> (cfg.mode == npss_pkg::MODE_JACOBI))
        else $error("diagonal fault outside jacobi mode");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (k_reg < KW'(DIV_CYCLES)))
        else $error("divider ran past its step count");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(result_value) && !empty))
        else $error("waiting result word changed");

endmodule

@@ rtl/nine_point_stencil_sweep_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_point_stencil_sweep_top: nine-point stencil sweep engine
// A*x, residual or damped jacobi update over a padded grid in raster order
// ----------------------------------------------------------------------------
// Usage
//   Input words (x, b and nine coefficients) are pushed with push/full in
//   raster order, ghost cells included. Each interior point yields one
//   result word on the empty/pop side; ghost points yield none.
//   For each word the front reads the line store and delay store, then
//   writes them back. Interior points then pass a two-entry job queue to
//   the arithmetic engine: A*x, residual and rejected diagonals run the
//   nine taps through one shared multiplier, and a jacobi update then
//   also runs the radix-4 divider.
//   A result passes the front, the job queue and the engine in turn.
//   When pop is held low the finished word waits in the output register,
//   the engine finishes the next job, then the queue fills and full stays high.
//   Configuration writes via cfg_valid/cfg_ready are always taken; write
//   only while no word is in flight. Reset clears position, window, state
//   and configuration registers; no clearing pass is run over the stores.
// ----------------------------------------------------------------------------
module nine_point_stencil_sweep_top #(
    parameter int MAX_ROW_LENGTH = npss_pkg::MAX_ROW_LENGTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [npss_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [npss_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] x_value,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] rhs_value,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_up_left,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_up,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_up_right,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_left,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_centre,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_right,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_down_left,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_down,
    input  logic signed [npss_pkg::VALUE_BITS-1:0] coef_down_right,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [npss_pkg::VALUE_BITS-1:0] result_value,
    output logic [npss_pkg::ROW_W-1:0]             point_row,
    output logic [npss_pkg::COL_W-1:0]             point_col,
    output logic                                   diag_fault,
    output logic                                   last_point
);

    npss_pkg::cfg_t cfg_reg;
    npss_pkg::job_t push_job, pop_job;
    logic           q_push, q_full, q_pop, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= npss_pkg::RST_MODE;
            cfg_reg.row_length <= npss_pkg::RST_ROW_LENGTH;
            cfg_reg.row_count  <= npss_pkg::RST_ROW_COUNT;
            cfg_reg.omega      <= npss_pkg::RST_OMEGA;
            cfg_reg.diag_tol   <= npss_pkg::RST_DIAG_TOL;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                npss_pkg::REG_MODE:
                    cfg_reg.mode <= cfg_data[npss_pkg::MODE_W-1:0];
                npss_pkg::REG_ROW_LENGTH:
                    cfg_reg.row_length <= cfg_data[npss_pkg::LEN_W-1:0];
                npss_pkg::REG_ROW_COUNT:
                    cfg_reg.row_count <= cfg_data[npss_pkg::CNT_W-1:0];
                npss_pkg::REG_OMEGA:
                    cfg_reg.omega <= cfg_data[npss_pkg::OMEGA_W-1:0];
                npss_pkg::REG_DIAG_TOL:
                    cfg_reg.diag_tol <= cfg_data[npss_pkg::TOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    npss_front #(
        .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .push            (push),
        .full            (full),
        .x_value         (x_value),
        .rhs_value       (rhs_value),
        .coef_up_left    (coef_up_left),
        .coef_up         (coef_up),
        .coef_up_right   (coef_up_right),
        .coef_left       (coef_left),
        .coef_centre     (coef_centre),
        .coef_right      (coef_right),
        .coef_down_left  (coef_down_left),
        .coef_down       (coef_down),
        .coef_down_right (coef_down_right),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_job           (push_job)
    );

    npss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    npss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .job_valid    (!q_empty),
        .job          (pop_job),
        .job_pop      (q_pop),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value),
        .point_row    (point_row),
        .point_col    (point_col),
        .diag_fault   (diag_fault),
        .last_point   (last_point)
    );

endmodule

@@ verif/nine_point_stencil_sweep_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_point_stencil_sweep_top_tb: self-checking bench for the stencil sweep
// Whole padded grids are pushed in raster order under every mode and a range
// of sizes, damping weights and tolerances. A built-in predictor of the line
// store, delay store and 3x3 window computes each interior result, and every
// popped word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module nine_point_stencil_sweep_top_tb;

    localparam int MODE_W         = npss_pkg::MODE_W;
    localparam int LEN_W          = npss_pkg::LEN_W;
    localparam int CNT_W          = npss_pkg::CNT_W;
    localparam int OMEGA_W        = npss_pkg::OMEGA_W;
    localparam int TOL_W          = npss_pkg::TOL_W;
    localparam int CFG_IDX_W      = npss_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W     = npss_pkg::CFG_DATA_W;
    localparam int VALUE_BITS     = npss_pkg::VALUE_BITS;
    localparam int FRAC_BITS      = npss_pkg::FRAC_BITS;
    localparam int TAPS           = npss_pkg::TAPS;
    localparam int CENTRE_TAP     = npss_pkg::CENTRE_TAP;
    localparam int ROW_W          = npss_pkg::ROW_W;
    localparam int COL_W          = npss_pkg::COL_W;
    localparam int MAX_ROW_LENGTH = npss_pkg::MAX_ROW_LENGTH;
    localparam int ROW_COUNT_MAX  = npss_pkg::ROW_COUNT_MAX;

    localparam logic [MODE_W-1:0]    RST_MODE       = npss_pkg::RST_MODE;
    localparam logic [LEN_W-1:0]     RST_ROW_LENGTH = npss_pkg::RST_ROW_LENGTH;
    localparam logic [CNT_W-1:0]     RST_ROW_COUNT  = npss_pkg::RST_ROW_COUNT;
    localparam logic [OMEGA_W-1:0]   RST_OMEGA      = npss_pkg::RST_OMEGA;
    localparam logic [TOL_W-1:0]     RST_DIAG_TOL   = npss_pkg::RST_DIAG_TOL;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = npss_pkg::REG_MODE;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = npss_pkg::REG_ROW_LENGTH;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = npss_pkg::REG_ROW_COUNT;
    localparam logic [CFG_IDX_W-1:0] REG_OMEGA      = npss_pkg::REG_OMEGA;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG_TOL   = npss_pkg::REG_DIAG_TOL;
    localparam logic [MODE_W-1:0]    MODE_AX        = npss_pkg::MODE_AX;
    localparam logic [MODE_W-1:0]    MODE_RESID     = npss_pkg::MODE_RESID;
    localparam logic [MODE_W-1:0]    MODE_JACOBI    = npss_pkg::MODE_JACOBI;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT  = 20000;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint PROD_CLAMP = 64'sd1 <<< 58;
    localparam longint ONE_Q = 64'sd1 <<< FRAC_BITS;

    typedef struct {
        logic signed [VALUE_BITS-1:0] x;
        logic signed [VALUE_BITS-1:0] rhs;
        logic signed [VALUE_BITS-1:0] coef [TAPS];
    } point_t;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic [ROW_W-1:0]             row;
        logic [COL_W-1:0]             col;
        logic                         fault;
        logic                         last;
    } stencil_out_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic push;
    logic full;
    logic signed [VALUE_BITS-1:0] x_value, rhs_value;
    logic signed [VALUE_BITS-1:0] coef_up_left, coef_up, coef_up_right;
    logic signed [VALUE_BITS-1:0] coef_left, coef_centre, coef_right;
    logic signed [VALUE_BITS-1:0] coef_down_left, coef_down, coef_down_right;
    logic empty;
    logic pop;
    logic signed [VALUE_BITS-1:0] result_value;
    logic [ROW_W-1:0] point_row;
    logic [COL_W-1:0] point_col;
    logic diag_fault;
    logic last_point;

    nine_point_stencil_sweep_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .x_value(x_value), .rhs_value(rhs_value),
        .coef_up_left(coef_up_left), .coef_up(coef_up), .coef_up_right(coef_up_right),
        .coef_left(coef_left), .coef_centre(coef_centre), .coef_right(coef_right),
        .coef_down_left(coef_down_left), .coef_down(coef_down),
        .coef_down_right(coef_down_right),
        .empty(empty), .pop(pop),
        .result_value(result_value), .point_row(point_row), .point_col(point_col),
        .diag_fault(diag_fault), .last_point(last_point)
    );

    // predictor state
    logic [MODE_W-1:0]  cur_mode;
    logic [LEN_W-1:0]   cur_row_length;
    logic [CNT_W-1:0]   cur_row_count;
    logic [OMEGA_W-1:0] cur_omega;
    logic [TOL_W-1:0]   cur_diag_tol;
    longint x_rows [2][MAX_ROW_LENGTH];
    longint centre_delay [MAX_ROW_LENGTH+2][TAPS+1];
    longint x_window [3][3];
    int unsigned row_pos;
    int unsigned col_pos;

    stencil_out_t expected_words [$];
    int err_count;
    int idle_cycles;
    int stall_left;
    bit idling_on;
    int items_sent;

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint sat_word(input longint v);
        if (v > VMAX)
            return VMAX;
        if (v < VMIN)
            return VMIN;
        return v;
    endfunction

    function automatic longint fixed_mul(input longint a, input longint b);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> FRAC_BITS;
        if (p > PROD_CLAMP)
            p = PROD_CLAMP;
        if (p < -PROD_CLAMP)
            p = -PROD_CLAMP;
        return p[63:0];
    endfunction

    function automatic longint fixed_div(input longint n, input longint d);
        longint un;
        longint ud;
        longint q;
        bit neg;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un <<< FRAC_BITS) / ud;
        if (q > VMAX + 1)
            q = VMAX + 1;
        return sat_word(neg ? -q : q);
    endfunction

    task automatic reset_predictor();
        cur_mode = RST_MODE;
        cur_row_length = RST_ROW_LENGTH;
        cur_row_count = RST_ROW_COUNT;
        cur_omega = RST_OMEGA;
        cur_diag_tol = RST_DIAG_TOL;
        foreach (x_rows[i, j])
            x_rows[i][j] = 0;
        foreach (centre_delay[i, j])
            centre_delay[i][j] = 0;
        foreach (x_window[i, j])
            x_window[i][j] = 0;
        row_pos = 0;
        col_pos = 0;
    endtask

    function automatic bit predict_stencil(input point_t p, output stencil_out_t w);
        int unsigned len, cnt, r, c, now, prv;
        longint cen [TAPS+1];
        longint sum, res, xc, diag, v, q, dmag;
        bit fault;
        bit hit;
        len = cur_row_length;
        cnt = cur_row_count;
        if (len < 3) len = 3;
        if (len > MAX_ROW_LENGTH) len = MAX_ROW_LENGTH;
        if (cnt < 3) cnt = 3;
        if (cnt > ROW_COUNT_MAX) cnt = ROW_COUNT_MAX;
        r = row_pos;
        c = col_pos;
        if (c >= MAX_ROW_LENGTH) c = MAX_ROW_LENGTH - 1;
        now = r & 1;
        prv = now ^ 1;
        sum = 0;
        fault = 0;
        hit = 0;
        w = '{default: '0};
        for (int i = 0; i < 3; i++)
        begin
            x_window[i][0] = x_window[i][1];
            x_window[i][1] = x_window[i][2];
        end
        x_window[0][2] = x_rows[now][c];
        x_window[1][2] = x_rows[prv][c];
        x_window[2][2] = p.x;
        x_rows[now][c] = p.x;
        for (int k = 0; k <= TAPS; k++)
        begin
            cen[k] = centre_delay[MAX_ROW_LENGTH][k];
            centre_delay[MAX_ROW_LENGTH][k] = centre_delay[c][k];
        end
        centre_delay[c][0] = p.rhs;
        for (int k = 0; k < TAPS; k++)
            centre_delay[c][1+k] = p.coef[k];
        if (r >= 2 && r <= cnt - 1 && c >= 2 && c <= len - 1)
        begin
            xc = x_window[1][1];
            diag = cen[1+CENTRE_TAP];
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    if (!(i == 1 && j == 1))
                        sum += fixed_mul(cen[1+i*3+j], x_window[i][j]);
            if (cur_mode == MODE_JACOBI)
            begin
                dmag = (diag < 0) ? -diag : diag;
                if (diag == 0 || dmag < longint'(cur_diag_tol))
                begin
                    fault = 1;
                    res = xc;
                end
                else
                begin
                    v = sat_word(cen[0] - sum);
                    q = fixed_div(v, diag);
                    res = sat_word(fixed_mul(ONE_Q - longint'(cur_omega), xc)
                                   + fixed_mul(longint'(cur_omega), q));
                end
            end
            else
            begin
                sum += fixed_mul(diag, xc);
                res = (cur_mode == MODE_RESID) ? sat_word(cen[0] - sum) : sat_word(sum);
            end
            w.value = res[VALUE_BITS-1:0];
            w.row = ROW_W'(r - 1);
            w.col = COL_W'(c - 1);
            w.fault = fault;
            w.last = (r == cnt - 1 && c == len - 1);
            hit = 1;
        end
        c++;
        if (c >= len)
        begin
            c = 0;
            r++;
        end
        if (r >= cnt) r = 0;
        row_pos = r;
        col_pos = c;
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MODE:       cur_mode = data[MODE_W-1:0];
            REG_ROW_LENGTH: cur_row_length = data[LEN_W-1:0];
            REG_ROW_COUNT:  cur_row_count = data[CNT_W-1:0];
            REG_OMEGA:      cur_omega = data[OMEGA_W-1:0];
            REG_DIAG_TOL:   cur_diag_tol = data[TOL_W-1:0];
            default: ;
        endcase
    endtask

    // all five registers, upper data bits random
    task automatic set_sweep(input logic [MODE_W-1:0] m, input int len, input int cnt,
                             input int om, input int tol);
        write_reg(REG_MODE, {$urandom} & ~32'h3 | m);
        write_reg(REG_ROW_LENGTH, {$urandom} & ~32'h7ff | len);
        write_reg(REG_ROW_COUNT, {$urandom} & ~32'h1fff | cnt);
        write_reg(REG_OMEGA, {$urandom} & ~32'h3ffff | om);
        write_reg(REG_DIAG_TOL, {$urandom} & ~32'hffff | tol);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(input point_t p);
        stencil_out_t w;
        if (idling_on && $urandom_range(0, 9) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        push <= 1'b1;
        x_value <= p.x;
        rhs_value <= p.rhs;
        coef_up_left <= p.coef[0];
        coef_up <= p.coef[1];
        coef_up_right <= p.coef[2];
        coef_left <= p.coef[3];
        coef_centre <= p.coef[4];
        coef_right <= p.coef[5];
        coef_down_left <= p.coef[6];
        coef_down <= p.coef[7];
        coef_down_right <= p.coef[8];
        do
            @(posedge clk);
        while (full);
        if (predict_stencil(p, w))
            expected_words.push_back(w);
        items_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] rand_word(input int wide);
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3, 4, 5, 6: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            default: return wide ? $signed($urandom) : $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    function automatic point_t make_point(input int wide, input int tol);
        point_t p;
        p.x = rand_word(1);
        p.rhs = rand_word(1);
        for (int k = 0; k < TAPS; k++)
            p.coef[k] = rand_word(wide);
        case ($urandom_range(0, 7))
            0: p.coef[CENTRE_TAP] = 0;
            1: p.coef[CENTRE_TAP] = tol - 1;
            2: p.coef[CENTRE_TAP] = -tol;
            3: p.coef[CENTRE_TAP] = tol;
            default: ;
        endcase
        return p;
    endfunction

    task automatic sweep_grid(input int len, input int cnt, input int wide, input int tol);
        int lc, cc;
        lc = (len < 3) ? 3 : (len > MAX_ROW_LENGTH ? MAX_ROW_LENGTH : len);
        cc = (cnt < 3) ? 3 : (cnt > ROW_COUNT_MAX ? ROW_COUNT_MAX : cnt);
        for (int i = 0; i < lc * cc; i++)
            send_point(make_point(wide, tol));
    endtask

    task automatic test_directed_extremes();
        logic signed [VALUE_BITS-1:0] edge_vals [6];
        logic signed [VALUE_BITS-1:0] diag_vals [6];
        point_t p;
        edge_vals = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh00010000, -32'sh00010000, 1};
        diag_vals = '{0, 1, -1, 32'sh7fffffff, 32'sh80000000, 32'sh00010000};
        set_sweep(MODE_JACOBI, 5, 4, 131072, 2);
        for (int i = 0; i < 20; i++)
        begin
            p.x = edge_vals[i % 6];
            p.rhs = edge_vals[(i + 3) % 6];
            for (int k = 0; k < TAPS; k++)
                p.coef[k] = edge_vals[(i + k) % 6];
            p.coef[CENTRE_TAP] = diag_vals[i % 6];
            send_point(p);
        end
        drain();
    endtask

    task automatic test_random_sweeps();
        logic [MODE_W-1:0] m;
        int len, cnt, om, tol;
        while (items_sent < 550)
        begin
            m = $urandom_range(0, 3);
            len = $urandom_range(3, 12);
            cnt = $urandom_range(3, 8);
            case ($urandom_range(0, 4))
                0: om = 0;
                1: om = 131072;
                2: om = $urandom_range(0, 262143);
                default: om = $urandom_range(0, 131072);
            endcase
            case ($urandom_range(0, 4))
                0: tol = 0;
                1: tol = 65535;
                default: tol = $urandom_range(0, 65535);
            endcase
            set_sweep(m, len, cnt, om, tol);
            sweep_grid(len, cnt, $urandom_range(0, 3) == 0, tol);
            drain();
        end
    endtask

    task automatic test_size_extremes();
        idling_on = 0;
        set_sweep(MODE_JACOBI, 64, 3, 49152, 100);
        sweep_grid(64, 3, 0, 100);
        drain();
        set_sweep(MODE_RESID, 3, 48, 0, 0);
        sweep_grid(3, 48, 0, 0);
        drain();
        set_sweep(MODE_SPARE, 0, 2, 65536, 1);
        sweep_grid(0, 2, 1, 1);
        drain();
        set_sweep(MODE_AX, 2, 1, 65536, 1);
        sweep_grid(2, 1, 0, 1);
        drain();
    endtask

    // result checker, pop stalls and watchdog
    always @(posedge clk)
    begin
        stencil_out_t w;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word, row", point_row, -1);
                else
                begin
                    w = expected_words.pop_front();
                    if (result_value !== w.value)
                        report_mismatch("result_value", result_value, w.value);
                    if (point_row !== w.row)
                        report_mismatch("point_row", point_row, w.row);
                    if (point_col !== w.col)
                        report_mismatch("point_col", point_col, w.col);
                    if (diag_fault !== w.fault)
                        report_mismatch("diag_fault", diag_fault, w.fault);
                    if (last_point !== w.last)
                        report_mismatch("last_point", last_point, w.last);
                end
            end
            if ((pop && !empty) || (push && !full))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 13);
            pop <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        pop = 1'b0;
        x_value = '0;
        rhs_value = '0;
        coef_up_left = '0;
        coef_up = '0;
        coef_up_right = '0;
        coef_left = '0;
        coef_centre = '0;
        coef_right = '0;
        coef_down_left = '0;
        coef_down = '0;
        coef_down_right = '0;
        err_count = 0;
        idle_cycles = 0;
        stall_left = 0;
        idling_on = 1;
        items_sent = 0;
        reset_predictor();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_random_sweeps();
        test_size_extremes();
        if (err_count == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
